// ----- rtl/integer_to_ascii_digits_top_macros.svh -----
// assertion macros shared by the integer to ascii digits modules
// each expects a signal named clock, and the second also one named reset
`ifndef INTEGER_TO_ASCII_DIGITS_TOP_MACROS_SVH
`define INTEGER_TO_ASCII_DIGITS_TOP_MACROS_SVH

// checked on every edge, also while reset is high
`define I2A_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

// checked only outside reset
`define I2A_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

// ----- rtl/i2a_pkg.sv -----
// types, codes and constants of the integer to ascii digits block
// no dependencies; used by the controller, the datapath and the top level
package i2a_pkg;

   localparam int NUM_DIGITS = 10;
   localparam int PTR_W      = $clog2(NUM_DIGITS);
   localparam int HEX_NIBBLES = 8;

   // floor(v / 10) == (v * RECIP_10) >> RECIP_SHIFT for every 32-bit v
   localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   localparam logic [6:0] CHAR_MINUS  = 7'h2D;
   localparam logic [6:0] CHAR_ZERO   = 7'h30;
   localparam logic [6:0] CHAR_LOWER_A = 7'h61;

   localparam logic [1:0] OP_SIGNED_DEC   = 2'd0;
   localparam logic [1:0] OP_UNSIGNED_DEC = 2'd1;
   localparam logic [1:0] OP_HEX          = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] number_bits;
   } req_type;

   typedef struct packed {
      logic [6:0] ascii_char;
      logic       last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_CONVERT = 4'b0010,
      ST_SIGN    = 4'b0100,
      ST_EMIT    = 4'b1000
   } state_type;

   typedef struct packed {
      logic load;
      logic conv_step;
      logic show_sign;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic conv_last;
      logic negative;
      logic ptr_zero;
   } stat_type;

   function automatic logic [6:0] digit_char(input logic [3:0] digit);
      logic [6:0] ch;
      if (digit < 4'd10) begin
         ch = CHAR_ZERO + 7'(digit);
      end else begin
         ch = CHAR_LOWER_A + 7'(digit - 4'd10);
      end
      return ch;
   endfunction

endpackage

// ----- rtl/i2a_datapath.sv -----
// datapath: value register, divide-by-ten step, digit buffer and character select
// depends on i2a_pkg
module i2a_datapath (
   input  logic              clock,
   input  i2a_pkg::cmd_type  cmd,
   input  i2a_pkg::req_type  req_data,
   output i2a_pkg::stat_type stat,
   output i2a_pkg::rsp_type  rsp_data
);
   import i2a_pkg::*;

   logic [31:0]      value_ff, value_in;
   logic             neg_ff, neg_in;
   logic             hex_ff, hex_in;
   logic [3:0]       digit_ff [NUM_DIGITS];
   logic [PTR_W-1:0] ptr_ff, ptr_in;

   logic [63:0]      product;
   logic [31:0]      quotient;
   logic [3:0]       q_x10_lo;
   logic [3:0]       remainder;
   logic             load_neg;
   logic [PTR_W-1:0] hex_top;

   // quotient and remainder of value / 10
   assign product   = 64'(value_ff) * 64'(RECIP_10);
   assign quotient  = 32'(product[63:RECIP_SHIFT]);
   assign q_x10_lo  = 4'({quotient[0], 3'b000}) + 4'({quotient[2:0], 1'b0});
   assign remainder = value_ff[3:0] - q_x10_lo;

   assign load_neg = (req_data.op == OP_SIGNED_DEC) && req_data.number_bits[31];

   // index of the most significant nonzero nibble, zero for a zero value
   always_comb begin
      hex_top = '0;
      for (int i = 0; i < HEX_NIBBLES; i++) begin
         if (req_data.number_bits[4*i +: 4] != 4'd0) begin
            hex_top = PTR_W'(i);
         end
      end
   end

   always_comb begin
      value_in = value_ff;
      neg_in   = neg_ff;
      hex_in   = hex_ff;
      ptr_in   = ptr_ff;
      if (cmd.load) begin
         hex_in   = req_data.op[1];
         neg_in   = load_neg;
         value_in = load_neg ? (~req_data.number_bits + 32'd1) : req_data.number_bits;
         ptr_in   = req_data.op[1] ? hex_top : '0;
      end else if (cmd.conv_step && !hex_ff) begin
         if (quotient != 32'd0) begin
            value_in = quotient;
            ptr_in   = ptr_ff + PTR_W'(1);
         end
      end else if (cmd.advance && !cmd.show_sign) begin
         ptr_in = ptr_ff - PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      neg_ff   <= neg_in;
      hex_ff   <= hex_in;
      ptr_ff   <= ptr_in;
      if (cmd.load && req_data.op[1]) begin
         for (int i = 0; i < HEX_NIBBLES; i++) begin
            digit_ff[i] <= req_data.number_bits[4*i +: 4];
         end
      end else if (cmd.conv_step && !hex_ff) begin
         digit_ff[ptr_ff] <= remainder;
      end
   end

   assign stat.conv_last = hex_ff || (quotient == 32'd0);
   assign stat.negative  = neg_ff;
   assign stat.ptr_zero  = (ptr_ff == '0);

   assign rsp_data.ascii_char = cmd.show_sign ? CHAR_MINUS : digit_char(digit_ff[ptr_ff]);
   assign rsp_data.last       = !cmd.show_sign && (ptr_ff == '0);

endmodule

// ----- rtl/i2a_controller.sv -----
// controller state machine: load, convert, optional sign, then one character per transfer
// depends on i2a_pkg and integer_to_ascii_digits_top_macros.svh
`include "integer_to_ascii_digits_top_macros.svh"

module i2a_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  i2a_pkg::stat_type stat,
   output i2a_pkg::cmd_type  cmd
);
   import i2a_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.conv_step = 1'b1;
            if (stat.conv_last) begin
               state_in = stat.negative ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            cmd.show_sign = 1'b1;
            cmd.advance   = !rsp_stall;
            if (!rsp_stall) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.advance = !rsp_stall;
            if (!rsp_stall && stat.ptr_zero) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_SIGN) || (state_ff == ST_EMIT);

   `I2A_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE), "not idle after reset")
   `I2A_ASSERT(a_accept_converts, (req_valid && !req_stall) |=> (state_ff == ST_CONVERT),
      "accepted value did not start conversion")
   `I2A_ASSERT(a_sign_only_negative, (state_ff == ST_SIGN) |-> stat.negative,
      "minus sign shown for a non-negative value")
   `I2A_ASSERT(a_last_ends_item, (state_ff == ST_EMIT && stat.ptr_zero && !rsp_stall) |=>
      (state_ff == ST_IDLE), "did not return to idle after last character")

endmodule

// ----- rtl/integer_to_ascii_digits_top.sv -----
// Converts one 32-bit value per request into its ASCII text (signed decimal, unsigned
// decimal or lower-case hexadecimal; op 3 acts as hexadecimal), one character per
// response transfer, most significant digit first, last set on the final character.
// One value is handled at a time. A decimal value is converted digit by digit through the
// multiply-by-reciprocal divide-by-ten step and a hex value is loaded whole; then the
// characters are sent (sign included), and the controller returns to idle before the
// next request is taken.
// Depends on i2a_pkg, i2a_controller and i2a_datapath.
module integer_to_ascii_digits_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  i2a_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output i2a_pkg::rsp_type rsp_data
);
   import i2a_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   i2a_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   i2a_datapath u_datapath (
      .clock    (clock),
      .cmd      (cmd),
      .req_data (req_data),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// testbench for integer_to_ascii_digits_top: values go in signed, unsigned and hex modes,
// and every character transfer that comes back is checked against a local text predictor
// depends on i2a_pkg and the integer_to_ascii_digits_top rtl
module tb_top;
   import i2a_pkg::*;

   localparam logic [1:0] OP_HEX_ALIAS  = 2'd3;   // unused code, behaves as hex
   localparam int         WATCHDOG_MAX  = 2000;
   localparam int         SETTLE_CYCLES = 30;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type expected_chars[$];
   int      send_gap_pct  = 0;
   int      rsp_stall_pct = 0;
   int      error_count   = 0;
   int      values_sent   = 0;
   int      chars_checked = 0;
   int      quiet_cycles  = 0;

   integer_to_ascii_digits_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // text of one value, most significant digit first
   function automatic void predict_text(input req_type item);
      string       digit_glyphs;
      logic [31:0] magnitude;
      logic [31:0] radix;
      logic [3:0]  digits[$];
      logic        negative;
      rsp_type     ch;
      digit_glyphs = "0123456789abcdef";
      negative = (item.op == OP_SIGNED_DEC) && item.number_bits[31];
      radix = (item.op == OP_SIGNED_DEC || item.op == OP_UNSIGNED_DEC) ? 32'd10 : 32'd16;
      magnitude = negative ? (~item.number_bits + 32'd1) : item.number_bits;
      do begin
         digits.push_front(4'(magnitude % radix));
         magnitude = magnitude / radix;
      end while (magnitude != 0);
      if (negative) begin
         ch.ascii_char = CHAR_MINUS;
         ch.last = 1'b0;
         expected_chars.push_back(ch);
      end
      foreach (digits[i]) begin
         ch.ascii_char = 7'(digit_glyphs[digits[i]]);
         ch.last = (i == digits.size() - 1);
         expected_chars.push_back(ch);
      end
   endfunction

   // valid stays high on return so back-to-back values need no extra edge
   task automatic send_number(input logic [1:0] op, input logic [31:0] value);
      req_type item;
      item.op = op;
      item.number_bits = value;
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      predict_text(item);
      values_sent++;
   endtask

   task automatic hold_off();
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_number(OP_SIGNED_DEC, 32'd0);
      send_number(OP_SIGNED_DEC, 32'd1);
      send_number(OP_SIGNED_DEC, 32'hFFFF_FFFF);
      send_number(OP_SIGNED_DEC, 32'h7FFF_FFFF);
      send_number(OP_SIGNED_DEC, 32'h8000_0000);
      send_number(OP_SIGNED_DEC, 32'hC465_3600);   // -1000000000
      send_number(OP_SIGNED_DEC, 32'd999_999_999);
      send_number(OP_UNSIGNED_DEC, 32'd0);
      send_number(OP_UNSIGNED_DEC, 32'd9);
      send_number(OP_UNSIGNED_DEC, 32'd10);
      send_number(OP_UNSIGNED_DEC, 32'd1_000_000_000);
      send_number(OP_UNSIGNED_DEC, 32'd4_000_000_000);
      send_number(OP_UNSIGNED_DEC, 32'hFFFF_FFFF);
      send_number(OP_UNSIGNED_DEC, 32'h8000_0000);
      send_number(OP_HEX, 32'd0);
      send_number(OP_HEX, 32'hF);
      send_number(OP_HEX, 32'h10);
      send_number(OP_HEX, 32'hDEAD_BEEF);
      send_number(OP_HEX, 32'hFFFF_FFFF);
      send_number(OP_HEX, 32'h8000_0000);
      send_number(OP_HEX_ALIAS, 32'd0);
      send_number(OP_HEX_ALIAS, 32'hABCD_EF01);
      send_number(OP_HEX_ALIAS, 32'hFFFF_FFFF);
   endtask

   // random shift spreads lengths from one digit to full width
   task automatic test_random(input int count);
      logic [1:0]  op;
      logic [31:0] value;
      repeat (count) begin
         op = ($urandom_range(9) == 0) ? OP_HEX_ALIAS : 2'($urandom_range(2));
         value = ($urandom_range(3) == 0) ? $urandom : ($urandom >> $urandom_range(31));
         send_number(op, value);
      end
   endtask

   task automatic test_drain_pause();
      send_number(OP_SIGNED_DEC, 32'h8000_0000);
      send_number(OP_UNSIGNED_DEC, $urandom);
      hold_off();
      wait_drained();
      send_number(OP_HEX, $urandom);
      send_number(OP_SIGNED_DEC, $urandom);
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // character transfer checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual char %h last %b",
                     $time, rsp_data.ascii_char, rsp_data.last);
            error_count++;
         end else begin
            want = expected_chars.pop_front();
            chars_checked++;
            if (rsp_data.ascii_char !== want.ascii_char) begin
               $display("%0t: ascii_char mismatch, expected %h, actual %h",
                        $time, want.ascii_char, rsp_data.ascii_char);
               error_count++;
            end
            if (rsp_data.last !== want.last) begin
               $display("%0t: last mismatch, expected %b, actual %b",
                        $time, want.last, rsp_data.last);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (!reset && rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
         $display("FAIL integer_to_ascii_digits_top");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_gap_pct = 7;
      rsp_stall_pct = 86;
      test_directed();
      test_random(30);

      send_gap_pct = 86;
      rsp_stall_pct = 7;
      test_random(30);
      test_drain_pause();

      send_gap_pct = 0;
      rsp_stall_pct = 0;
      test_random(30);

      hold_off();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d values in all four mode codes, %0d characters checked,",
               values_sent, chars_checked);
      $display("with sender gaps, receiver stalls and a full drain pause; %0d errors",
               error_count);
      if (error_count == 0) begin
         $display("PASS integer_to_ascii_digits_top");
      end else begin
         $display("FAIL integer_to_ascii_digits_top");
      end
      $finish;
   end

endmodule
